/* rtl/stirs_pkg.sv */
// Package for the sorted table: payload words, command and status codes, sequencer states.
package stirs_pkg;

  // Default number of table entries.
  localparam int unsigned TableDepthDefault = 32;

  // Status codes carried in a result word.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } stirs_status_t;

  // Command codes carried in an input word. Code 3 is decoded as a search.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } stirs_cmd_t;

  // Operation held by the sequencer while a word is in progress.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_SEARCH
  } stirs_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_LAST,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT
  } stirs_state_t;

  // Input word.
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } stirs_in_t;

  // Result word.
  typedef struct packed {
    stirs_status_t status;
    logic [4:0]    position;
    logic [5:0]    fill_after;
  } stirs_out_t;

endpackage

/* rtl/stirs_table_ram.sv */
// Table storage: one write port and one read port with registered read data.
module stirs_table_ram #(
  parameter int unsigned DEPTH = stirs_pkg::TableDepthDefault
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [31:0]                wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [31:0]                rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sorted_table_insert_remove_search.sv */
// Top level of the sorted table: command sequencer around the table memory.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+----------------------------------------
//   input    | start, busy, in_data     | word taken when start is high, busy low
//   result   | out_valid, out_data      | one-cycle strobe, cannot be held off
//
// Every input word gives exactly one result word. A word that needs no table
// read (add on a full table, search or remove on an empty one, add on an
// empty table) returns its result on the cycle after it is taken. Otherwise the
// cost is set by the single read port of the table memory: a search reads and
// then compares the entry at each binary-search probe and makes at most
// floor(log2(count)) + 1 probes, an add scans down from the top entry one entry
// a cycle while it moves entries up, and a remove, once its search has hit, moves the
// entries above the hit down one entry a cycle. With 32 entries the longest word
// is a remove of entry zero from a full table.
// Reset is synchronous and active low; it empties the table by clearing the
// fill count, and no clearing pass over the memory is needed. Busy stays high
// while a word is in progress and the result strobe shows on the cycle busy
// falls, so a new word can be taken on the same cycle its predecessor's result
// is shown.
module sorted_table_insert_remove_search #(
  parameter int unsigned TABLE_DEPTH = stirs_pkg::TableDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  stirs_pkg::stirs_in_t in_data,
  output logic                 busy,
  output logic                 out_valid,
  output stirs_pkg::stirs_out_t out_data
);

  // Index width for the memory and count width able to hold TABLE_DEPTH itself.
  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  // Widths used to fit indices and counts into the fixed result fields.
  localparam int unsigned PW = (IW > 5) ? IW : 5;
  localparam int unsigned FW = (CW > 6) ? CW : 6;

  stirs_pkg::stirs_state_t state_r, state_nxt;
  stirs_pkg::stirs_op_t    op_r, op_nxt;
  logic signed [31:0]      key_r, key_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [IW-1:0]           addr_r, addr_nxt;
  logic [IW-1:0]           mid_r, mid_nxt;
  logic [CW-1:0]           lo_r, lo_nxt;
  logic [CW-1:0]           hb_r, hb_nxt;
  logic                    out_valid_r, out_valid_nxt;
  stirs_pkg::stirs_out_t   out_r, out_nxt;

  // Table memory port signals.
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // Result being formed on this cycle.
  logic                    res_fire;
  stirs_pkg::stirs_status_t res_status;
  logic [IW-1:0]           res_pos;
  logic [CW-1:0]           res_fill;
  logic [PW-1:0]           res_pos_ext;
  logic [FW-1:0]           res_fill_ext;

  stirs_table_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The input word is taken only while the sequencer is idle.
  logic accept;
  assign busy   = (state_r != stirs_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Decode of the incoming command; code 3 falls through to search.
  stirs_pkg::stirs_op_t in_op;
  always_comb begin
    case (in_data.command)
      stirs_pkg::CMD_ADD:    in_op = stirs_pkg::OP_ADD;
      stirs_pkg::CMD_REMOVE: in_op = stirs_pkg::OP_REMOVE;
      default:               in_op = stirs_pkg::OP_SEARCH;
    endcase
  end

  // Conditions shared by the next-state and datapath logic.
  logic          tbl_full;
  logic          tbl_empty;
  logic          rd_gt_key;
  logic          rd_eq_key;
  logic [CW-1:0] count_m1;
  logic [IW-1:0] last_idx;
  logic [CW:0]   mid_sum;
  logic [IW-1:0] mid_calc;
  logic [CW-1:0] mid_ext;
  logic [CW-1:0] lo_step;
  logic [CW-1:0] hb_step;
  logic          range_open;

  assign tbl_full  = (count_r == CW'(TABLE_DEPTH));
  assign tbl_empty = (count_r == '0);
  assign rd_gt_key = ($signed(mem_rdata) > key_r);
  assign rd_eq_key = ($signed(mem_rdata) == key_r);
  assign count_m1  = count_r - CW'(1);
  assign last_idx  = count_m1[IW-1:0];

  // The upper bound is kept one past the last candidate (hb = hi + 1), so the
  // probe index (lo + hi) / 2 becomes (lo + hb - 1) / 2 and never goes negative.
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hb_r} - (CW + 1)'(1);
  assign mid_calc = mid_sum[IW:1];
  assign mid_ext  = CW'(mid_r);

  // Bounds after the compare of the probed entry, for a miss on that entry.
  assign lo_step    = rd_gt_key ? lo_r : (mid_ext + CW'(1));
  assign hb_step    = rd_gt_key ? mid_ext : hb_r;
  assign range_open = (lo_step < hb_step);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stirs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == stirs_pkg::OP_ADD) begin
            if (!tbl_full && !tbl_empty) begin
              state_nxt = stirs_pkg::ST_ADD_SCAN;
            end
          end else if (!tbl_empty) begin
            state_nxt = stirs_pkg::ST_PROBE;
          end
        end
      end
      stirs_pkg::ST_ADD_SCAN: begin
        if (!rd_gt_key) begin
          state_nxt = stirs_pkg::ST_IDLE;
        end else if (addr_r == '0) begin
          state_nxt = stirs_pkg::ST_ADD_LAST;
        end
      end
      stirs_pkg::ST_ADD_LAST: begin
        state_nxt = stirs_pkg::ST_IDLE;
      end
      stirs_pkg::ST_PROBE: begin
        state_nxt = stirs_pkg::ST_CMP;
      end
      stirs_pkg::ST_CMP: begin
        if (rd_eq_key) begin
          if (op_r == stirs_pkg::OP_REMOVE && mid_r != last_idx) begin
            state_nxt = stirs_pkg::ST_SHIFT;
          end else begin
            state_nxt = stirs_pkg::ST_IDLE;
          end
        end else if (range_open) begin
          state_nxt = stirs_pkg::ST_PROBE;
        end else begin
          state_nxt = stirs_pkg::ST_IDLE;
        end
      end
      stirs_pkg::ST_SHIFT: begin
        if (addr_r == last_idx) begin
          state_nxt = stirs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stirs_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output logic: memory accesses, bounds, count and result.
  always_comb begin
    op_nxt     = op_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    mid_nxt    = mid_r;
    lo_nxt     = lo_r;
    hb_nxt     = hb_r;
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = addr_r;
    res_fire   = 1'b0;
    res_status = stirs_pkg::STATUS_OK;
    res_pos    = '0;
    res_fill   = count_r;

    case (state_r)
      stirs_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_op;
          key_nxt = in_data.value;
          if (in_op == stirs_pkg::OP_ADD) begin
            if (tbl_full) begin
              res_fire   = 1'b1;
              res_status = stirs_pkg::STATUS_FULL;
            end else if (tbl_empty) begin
              // First entry goes straight to the bottom of the table.
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = in_data.value;
              count_nxt = CW'(1);
              res_fire  = 1'b1;
              res_fill  = CW'(1);
            end else begin
              // Start the downward scan at the top entry.
              mem_raddr = last_idx;
              addr_nxt  = last_idx;
            end
          end else if (tbl_empty) begin
            res_fire   = 1'b1;
            res_status = stirs_pkg::STATUS_MISS;
          end else begin
            lo_nxt = '0;
            hb_nxt = count_r;
          end
        end
      end

      stirs_pkg::ST_ADD_SCAN: begin
        // The entry read last cycle is at addr_r. While it is larger than the
        // key it moves up by one and the scan goes on with the entry below.
        mem_we    = 1'b1;
        mem_waddr = addr_r + IW'(1);
        if (rd_gt_key) begin
          mem_wdata = mem_rdata;
          mem_raddr = addr_r - IW'(1);
          addr_nxt  = addr_r - IW'(1);
        end else begin
          mem_wdata = key_r;
          count_nxt = count_r + CW'(1);
          res_fire  = 1'b1;
          res_pos   = addr_r + IW'(1);
          res_fill  = count_r + CW'(1);
        end
      end

      stirs_pkg::ST_ADD_LAST: begin
        // Every entry was larger than the key, so it lands at index zero.
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key_r;
        count_nxt = count_r + CW'(1);
        res_fire  = 1'b1;
        res_fill  = count_r + CW'(1);
      end

      stirs_pkg::ST_PROBE: begin
        mem_raddr = mid_calc;
        mid_nxt   = mid_calc;
      end

      stirs_pkg::ST_CMP: begin
        if (rd_eq_key) begin
          if (op_r == stirs_pkg::OP_REMOVE) begin
            if (mid_r != last_idx) begin
              // Close the gap: read the entry above the hit first.
              mem_raddr = mid_r + IW'(1);
              addr_nxt  = mid_r + IW'(1);
            end else begin
              count_nxt = count_m1;
              res_fire  = 1'b1;
              res_pos   = mid_r;
              res_fill  = count_m1;
            end
          end else begin
            res_fire = 1'b1;
            res_pos  = mid_r;
          end
        end else begin
          lo_nxt = lo_step;
          hb_nxt = hb_step;
          if (!range_open) begin
            res_fire   = 1'b1;
            res_status = stirs_pkg::STATUS_MISS;
          end
        end
      end

      stirs_pkg::ST_SHIFT: begin
        // The entry read last cycle at addr_r moves down by one while the
        // next one up is read.
        mem_we    = 1'b1;
        mem_waddr = addr_r - IW'(1);
        mem_wdata = mem_rdata;
        if (addr_r == last_idx) begin
          count_nxt = count_m1;
          res_fire  = 1'b1;
          res_pos   = mid_r;
          res_fill  = count_m1;
        end else begin
          mem_raddr = addr_r + IW'(1);
          addr_nxt  = addr_r + IW'(1);
        end
      end

      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Fit the index and count into the fixed result fields.
  assign res_pos_ext  = PW'(res_pos);
  assign res_fill_ext = FW'(res_fill);

  always_comb begin
    out_valid_nxt       = res_fire;
    out_nxt             = out_r;
    if (res_fire) begin
      out_nxt.status     = res_status;
      out_nxt.position   = res_pos_ext[4:0];
      out_nxt.fill_after = res_fill_ext[5:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stirs_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    addr_r <= addr_nxt;
    mid_r  <= mid_nxt;
    lo_r   <= lo_nxt;
    hb_r   <= hb_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/stirs_checker.sv */
// Port-level checker for the sorted table, attached to the top level by bind.
module stirs_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input stirs_pkg::stirs_out_t out_data
);

  // Reset leaves the block idle with no result showing.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // A result is shown only on a cycle where the block is idle again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A taken word either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted word neither finished nor in progress");

  // Failed operations report position zero.
  a_fail_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == stirs_pkg::STATUS_FULL ||
                   out_data.status == stirs_pkg::STATUS_MISS))
      |-> (out_data.position == 5'd0))
    else $error("nonzero position on a failed operation");

endmodule

bind sorted_table_insert_remove_search stirs_checker u_stirs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* sim/testbench.sv */
// Testbench for the sorted table: random and directed commands checked against a predictor.
`timescale 1ns / 1ps

// The checker keeps its own copy of the table and the fill level. Every taken input word
// is applied to that copy at once, and the result word it must produce is queued in
// order. Since the block answers every word exactly once and in order, each result
// strobe is compared with the oldest queued word.
class table_checker;
  localparam int Depth = stirs_pkg::TableDepthDefault;

  logic signed [31:0]   slots [Depth];
  int                   fill_level;
  stirs_pkg::stirs_out_t pending_results [$];
  int                   errors;

  function new();
    fill_level = 0;
    errors = 0;
  endfunction

  // Binary search over the valid entries with the same probe order as the block.
  // It returns the index of the first equal entry that a probe hits, or -1.
  function int probe_index(logic signed [31:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = fill_level - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key == slots[mid]) return mid;
      if (key > slots[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  // Apply one taken word to the table copy and queue the result it must produce.
  function void note_word(stirs_pkg::stirs_in_t w);
    stirs_pkg::stirs_out_t r;
    int p;
    int hit;
    r.status = stirs_pkg::STATUS_OK;
    p = 0;
    if (w.command == stirs_pkg::CMD_ADD) begin
      if (fill_level >= Depth) begin
        r.status = stirs_pkg::STATUS_FULL;
      end else begin
        // The new value goes after every entry less than or equal to it.
        while (p < fill_level && slots[p] <= w.value) p++;
        for (int i = fill_level; i > p; i--) slots[i] = slots[i - 1];
        slots[p] = w.value;
        fill_level++;
      end
    end else if (w.command == stirs_pkg::CMD_REMOVE) begin
      hit = probe_index(w.value);
      if (hit < 0) begin
        r.status = stirs_pkg::STATUS_MISS;
      end else begin
        for (int i = hit; i + 1 < fill_level; i++) slots[i] = slots[i + 1];
        fill_level--;
        p = hit;
      end
    end else begin
      // Search, and the unused code, which the block decodes as a search.
      hit = probe_index(w.value);
      if (hit < 0) r.status = stirs_pkg::STATUS_MISS;
      else p = hit;
    end
    r.position = p[4:0];
    r.fill_after = fill_level[5:0];
    pending_results.push_back(r);
  endfunction

  function void check_word(stirs_pkg::stirs_out_t got);
    stirs_pkg::stirs_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result word with none expected, actual status %0d position %0d fill %0d",
               $time, got.status, got.position, got.fill_after);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d",
               $time, want.status, got.status);
      errors++;
    end
    if (got.position !== want.position) begin
      $display("%0t: position mismatch, expected %0d, actual %0d",
               $time, want.position, got.position);
      errors++;
    end
    if (got.fill_after !== want.fill_after) begin
      $display("%0t: fill count mismatch, expected %0d, actual %0d",
               $time, want.fill_after, got.fill_after);
      errors++;
    end
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // Any word still queued at the end was never answered.
  function void flush_leftovers();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_results.size());
      errors += pending_results.size();
    end
  endfunction
endclass

module testbench;
  import stirs_pkg::*;

  // The command field has one code that the package does not name; the block treats it
  // as a search.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Command mixes used by the random part. Growing runs fill the table up to the point
  // where adds fail, shrinking runs drain it to the point where removes miss.
  localparam int MIX_GROW = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN = 2;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  stirs_in_t  in_data = '0;
  logic       busy;
  logic       out_valid;
  stirs_out_t out_data;

  table_checker sb = new();

  // Values that were added recently. Removes and searches draw on these so that most of
  // them hit, and duplicates pile up.
  logic signed [31:0] added_values [$];

  sorted_table_insert_remove_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Monitor. All inputs change by nonblocking assignment at the rising edge, so the
  // values read here are those the block saw at this edge. A result is checked before
  // the word taken at the same edge is noted, since that word cannot be answered yet.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_word(out_data);
      if (start && !busy) sb.note_word(in_data);
    end
  end

  // Present one word and hold it until the block takes it. Start is left high on return;
  // the next call either replaces the word or lowers start, so it is assigned once per edge.
  task automatic send_word(input logic [1:0] cmd, input logic signed [31:0] val);
    start <= 1'b1;
    in_data <= '{command: cmd, value: val};
    if (cmd == CMD_ADD) begin
      added_values.push_back(val);
      if (added_values.size() > 48) void'(added_values.pop_front());
    end
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender off until every queued result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Small values in four of ten draws, so that duplicates and near misses are common, plus the
  // extremes in one and full-width random values in five, so that every bit of the field toggles.
  function automatic logic signed [31:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if (pick <= 4) return $signed($urandom_range(0, 15)) - 32'sd8;
    return $signed($urandom);
  endfunction

  function automatic logic signed [31:0] lookup_value();
    if (added_values.size() != 0 && $urandom_range(0, 99) < 65)
      return added_values[$urandom_range(0, added_values.size() - 1)];
    return random_value();
  endfunction

  // One stretch of random words. Gap_pct is the chance, per cycle, that the sender
  // stays idle before presenting the next word.
  task automatic run_random(input int n_words, input int gap_pct);
    int mix;
    int roll;
    int add_cut;
    int remove_cut;
    mix = MIX_EVEN;
    for (int i = 0; i < n_words; i++) begin
      if (i % 80 == 0) mix = $urandom_range(MIX_GROW, MIX_EVEN);
      case (mix)
        MIX_GROW: begin
          add_cut = 70;
          remove_cut = 85;
        end
        MIX_SHRINK: begin
          add_cut = 15;
          remove_cut = 75;
        end
        default: begin
          add_cut = 35;
          remove_cut = 65;
        end
      endcase
      while ($urandom_range(0, 99) < gap_pct) idle_cycle();
      roll = $urandom_range(0, 99);
      if (roll < add_cut) send_word(CMD_ADD, random_value());
      else if (roll < remove_cut) send_word(CMD_REMOVE, lookup_value());
      else if (roll < 97) send_word(CMD_SEARCH, lookup_value());
      else send_word(CMD_UNUSED, lookup_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty table first: every lookup must miss, including the
    // unused code.
    send_word(CMD_SEARCH, 32'sd0);
    send_word(CMD_REMOVE, 32'sd0);
    send_word(CMD_UNUSED, 32'sd0);
    // The extremes of the value range and minus one, then duplicates of zero and of the maximum.
    send_word(CMD_ADD, 32'sh7fff_ffff);
    send_word(CMD_ADD, 32'sh8000_0000);
    send_word(CMD_ADD, 32'sd0);
    send_word(CMD_ADD, -32'sd1);
    send_word(CMD_ADD, 32'sd0);
    send_word(CMD_ADD, 32'sd0);
    send_word(CMD_ADD, 32'sh7fff_ffff);
    // Lookups at both ends, among the duplicates, and misses between entries.
    send_word(CMD_SEARCH, 32'sh8000_0000);
    send_word(CMD_SEARCH, 32'sh7fff_ffff);
    send_word(CMD_SEARCH, 32'sd0);
    send_word(CMD_UNUSED, 32'sd0);
    send_word(CMD_SEARCH, 32'sd5);
    send_word(CMD_SEARCH, 32'sh8000_0001);
    // Removes at the front, in the middle among duplicates, and of the largest value.
    send_word(CMD_REMOVE, 32'sh8000_0000);
    send_word(CMD_REMOVE, 32'sd0);
    send_word(CMD_REMOVE, 32'sh7fff_ffff);
    send_word(CMD_REMOVE, 32'sd1);
    send_word(CMD_ADD, 32'sd1);
    send_word(CMD_SEARCH, 32'sd1);

    // Let everything settle once before the random part.
    wait_drained();

    run_random(350, 6);
    wait_drained();
    run_random(350, 76);
    wait_drained();
    run_random(350, 0);

    // Wait for the last answers, then a little longer in case anything stray follows.
    wait_drained();
    repeat (60) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A correct run takes well under a millisecond of simulated time even with the
  // longest gaps; this bound only catches a block that stops answering.
  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/stirs_pkg.sv
rtl/stirs_table_ram.sv
rtl/sorted_table_insert_remove_search.sv
rtl/stirs_checker.sv
sim/testbench.sv
